### hw/rtl/crc16_framed_link_receiver_assert.svh
// Assertion macros shared by the link receiver RTL.
`ifndef CRC16_FRAMED_LINK_RECEIVER_ASSERT_SVH
`define CRC16_FRAMED_LINK_RECEIVER_ASSERT_SVH

// Same-cycle implication, checked on clk and masked during reset.
`define CFLR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("link receiver check failed");

// Next-cycle implication, checked on clk and masked during reset.
`define CFLR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("link receiver check failed");

`endif

### hw/rtl/cflr_pkg.sv
// Shared types, constants and the CRC byte update for the link receiver.
`default_nettype none

package cflr_pkg;

	localparam int unsigned LEN_W = 11;
	localparam logic [15:0] MAX_PAYLOAD = 16'd1024;

	localparam logic [7:0]  SYNC0        = 8'hAC;
	localparam logic [7:0]  SYNC1        = 8'h9D;
	localparam logic [7:0]  LINK_VERSION = 8'h01;
	localparam logic [15:0] CRC_INIT     = 16'hFFFF;
	localparam logic [15:0] CRC_POLY     = 16'h1021;

	// Event codes
	localparam logic [2:0] EV_DATA = 3'd0;
	localparam logic [2:0] EV_GOOD = 3'd1;
	localparam logic [2:0] EV_CRC  = 3'd2;
	localparam logic [2:0] EV_VER  = 3'd3;
	localparam logic [2:0] EV_LEN  = 3'd4;

	// Route codes
	localparam logic [1:0] ROUTE_GROUND = 2'd0;
	localparam logic [1:0] ROUTE_SWARM  = 2'd1;
	localparam logic [1:0] ROUTE_NONE   = 2'd2;

	// Configuration register indexes
	localparam logic REG_LOCAL_ADDR  = 1'b0;
	localparam logic REG_GROUND_ADDR = 1'b1;

	// One result beat
	typedef struct packed {
		logic [2:0]       event_res;
		logic [7:0]       data;
		logic [7:0]       source_id;
		logic [7:0]       dest_id;
		logic [1:0]       route;
		logic [LEN_W-1:0] payload_length;
		logic             last;
	} res_t;

	// CRC-16/CCITT-FALSE update by one byte, MSB first
	function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/crc16_framed_link_receiver.sv
// Top level of the framed link receiver: deframer, CRC check and result buffer.
`default_nettype none

// Framed link receiver. Takes one received byte per beat on rx_byte and hunts
// for the sync pair 0xAC 0x9D, then checks version, reads source, destination
// and a big-endian length, runs CRC-16/CCITT-FALSE over header and payload and
// compares it with the trailing big-endian CRC. Payload bytes of frames routed
// here come out as event 0 beats as they arrive; every frame ends in one
// verdict beat with last set. A byte is accepted every cycle while in_stall is low:
// the header checks and the byte-wide CRC update sit between the input and a
// result register; an accepted byte's result is registered there, or in the
// one-entry skid behind it while a result still waits, so the receiver can
// take a byte then; in_stall rises only while that skid is occupied. Write
// local_address (index 0) and ground_address (index 1) only while the link
// is idle; route is latched at the destination byte. After any error the
// hunt restarts at the next byte, with no rescan.
module crc16_framed_link_receiver (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// Configuration write port
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_index,
	input  wire logic [7:0]                  cfg_data,
	// Input byte channel
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [7:0]                  rx_byte,
	// Result channel
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [2:0]                       event_res,
	output logic [7:0]                       data,
	output logic [7:0]                       source_id,
	output logic [7:0]                       dest_id,
	output logic [1:0]                       route,
	output logic [cflr_pkg::LEN_W-1:0]       payload_length,
	output logic                             last
);
	import cflr_pkg::*;

	`include "crc16_framed_link_receiver_assert.svh"

	// Phase codes
	localparam logic [3:0] PH_HUNT0 = 4'd0;
	localparam logic [3:0] PH_HUNT1 = 4'd1;
	localparam logic [3:0] PH_VER   = 4'd2;
	localparam logic [3:0] PH_SRC   = 4'd3;
	localparam logic [3:0] PH_DST   = 4'd4;
	localparam logic [3:0] PH_LENH  = 4'd5;
	localparam logic [3:0] PH_LENL  = 4'd6;
	localparam logic [3:0] PH_PAY   = 4'd7;
	localparam logic [3:0] PH_CRCH  = 4'd8;
	localparam logic [3:0] PH_CRCL  = 4'd9;

	logic [7:0]       local_addr_q;
	logic [7:0]       ground_addr_q;

	logic [3:0]       phase_q, phase_d;
	logic [LEN_W-1:0] byte_idx_q, byte_idx_d;
	logic [15:0]      crc_q, crc_d;
	logic [7:0]       src_q, src_d;
	logic [7:0]       dst_q, dst_d;
	logic [7:0]       len_hi_q, len_hi_d;
	logic [LEN_W-1:0] frame_len_q, frame_len_d;
	logic [1:0]       route_q, route_d;
	logic [7:0]       crc_hi_q, crc_hi_d;

	logic             in_fire;
	logic             out_fire;
	logic             has_res;
	res_t             res_d;
	res_t             res_q;
	res_t             skid_q;
	logic             out_valid_q;
	logic             skid_valid_q;

	logic [15:0]      crc_base;
	logic [15:0]      crc_next;
	logic [15:0]      len_full;
	logic [LEN_W-1:0] idx_inc;

	assign in_fire  = in_valid & ~in_stall;
	assign out_fire = out_valid_q & ~out_stall;
	assign in_stall = skid_valid_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_addr_q  <= '0;
			ground_addr_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LOCAL_ADDR:  local_addr_q  <= cfg_data;
				REG_GROUND_ADDR: ground_addr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// CRC restarts from init on every fresh first sync byte
	always_comb begin
		if (phase_q == PH_HUNT0 || (phase_q == PH_HUNT1 && rx_byte == SYNC0)) begin
			crc_base = CRC_INIT;
		end else begin
			crc_base = crc_q;
		end
	end

	assign crc_next = crc_feed(crc_base, rx_byte);
	assign len_full = {len_hi_q, rx_byte};
	assign idx_inc  = byte_idx_q + LEN_W'(1);

	// Deframer next state and result
	always_comb begin
		phase_d     = phase_q;
		byte_idx_d  = byte_idx_q;
		crc_d       = crc_q;
		src_d       = src_q;
		dst_d       = dst_q;
		len_hi_d    = len_hi_q;
		frame_len_d = frame_len_q;
		route_d     = route_q;
		crc_hi_d    = crc_hi_q;
		has_res     = 1'b0;
		res_d       = '{event_res: EV_DATA, data: 8'h00, source_id: src_q, dest_id: dst_q,
			route: route_q, payload_length: frame_len_q, last: 1'b0};

		unique case (phase_q)
			PH_HUNT0: begin
				if (rx_byte == SYNC0) begin
					crc_d   = crc_next;
					phase_d = PH_HUNT1;
				end
			end
			PH_HUNT1: begin
				if (rx_byte == SYNC1) begin
					crc_d   = crc_next;
					phase_d = PH_VER;
				end else if (rx_byte == SYNC0) begin
					crc_d   = crc_next;
				end else begin
					phase_d = PH_HUNT0;
				end
			end
			PH_VER: begin
				if (rx_byte != LINK_VERSION) begin
					phase_d = PH_HUNT0;
					has_res = 1'b1;
					res_d   = '{event_res: EV_VER, data: 8'h00, source_id: 8'h00,
						dest_id: 8'h00, route: ROUTE_NONE, payload_length: '0, last: 1'b1};
				end else begin
					crc_d   = crc_next;
					phase_d = PH_SRC;
				end
			end
			PH_SRC: begin
				src_d   = rx_byte;
				crc_d   = crc_next;
				phase_d = PH_DST;
			end
			PH_DST: begin
				dst_d   = rx_byte;
				crc_d   = crc_next;
				phase_d = PH_LENH;
				if (src_q == ground_addr_q && rx_byte == local_addr_q) begin
					route_d = ROUTE_GROUND;
				end else if (rx_byte != local_addr_q && rx_byte != 8'h00) begin
					route_d = ROUTE_NONE;
				end else begin
					route_d = ROUTE_SWARM;
				end
			end
			PH_LENH: begin
				len_hi_d = rx_byte;
				crc_d    = crc_next;
				phase_d  = PH_LENL;
			end
			PH_LENL: begin
				if (len_full > MAX_PAYLOAD) begin
					phase_d = PH_HUNT0;
					has_res = 1'b1;
					res_d   = '{event_res: EV_LEN, data: 8'h00, source_id: src_q,
						dest_id: dst_q, route: route_q, payload_length: '0, last: 1'b1};
				end else begin
					frame_len_d = len_full[LEN_W-1:0];
					crc_d       = crc_next;
					byte_idx_d  = '0;
					phase_d     = (len_full == 16'h0000) ? PH_CRCH : PH_PAY;
				end
			end
			PH_PAY: begin
				crc_d      = crc_next;
				byte_idx_d = idx_inc;
				if (idx_inc >= frame_len_q) begin
					phase_d = PH_CRCH;
				end
				if (route_q != ROUTE_NONE) begin
					has_res    = 1'b1;
					res_d.data = rx_byte;
				end
			end
			PH_CRCH: begin
				crc_hi_d = rx_byte;
				phase_d  = PH_CRCL;
			end
			PH_CRCL: begin
				phase_d = PH_HUNT0;
				has_res = 1'b1;
				res_d.event_res = ({crc_hi_q, rx_byte} == crc_q) ? EV_GOOD : EV_CRC;
				res_d.last      = 1'b1;
			end
			default: begin
				phase_d = PH_HUNT0;
			end
		endcase
	end

	// Deframer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT0;
			byte_idx_q  <= '0;
			crc_q       <= CRC_INIT;
			src_q       <= '0;
			dst_q       <= '0;
			len_hi_q    <= '0;
			frame_len_q <= '0;
			route_q     <= ROUTE_GROUND;
			crc_hi_q    <= '0;
		end else if (in_fire) begin
			phase_q     <= phase_d;
			byte_idx_q  <= byte_idx_d;
			crc_q       <= crc_d;
			src_q       <= src_d;
			dst_q       <= dst_d;
			len_hi_q    <= len_hi_d;
			frame_len_q <= frame_len_d;
			route_q     <= route_d;
			crc_hi_q    <= crc_hi_d;
		end
	end

	// Result register and one-entry skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_fire) begin
				skid_valid_q <= 1'b0;
			end
		end else if (in_fire && has_res) begin
			if (!out_valid_q || out_fire) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload follows the same moves as the valid bits
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire) begin
				res_q <= skid_q;
			end
		end else if (in_fire && has_res) begin
			if (!out_valid_q || out_fire) begin
				res_q <= res_d;
			end else begin
				skid_q <= res_d;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign event_res      = res_q.event_res;
	assign data           = res_q.data;
	assign source_id      = res_q.source_id;
	assign dest_id        = res_q.dest_id;
	assign route          = res_q.route;
	assign payload_length = res_q.payload_length;
	assign last           = res_q.last;

	// Skid only fills behind a held result
	`CFLR_ASSERT_NOW(a_skid_behind_out, skid_valid_q, out_valid_q)
	// Payload beats never come from frames routed elsewhere
	`CFLR_ASSERT_NOW(a_data_routed, out_valid_q && res_q.event_res == EV_DATA,
		res_q.route != ROUTE_NONE && !res_q.last)
	// The low CRC byte always yields a verdict beat
	`CFLR_ASSERT_NEXT(a_crc_verdict, in_fire && phase_q == PH_CRCL, out_valid_q)
	// Payload counter stays below the frame length
	`CFLR_ASSERT_NOW(a_idx_bound, phase_q == PH_PAY, byte_idx_q < frame_len_q)

endmodule

`default_nettype wire
